// File: sv/rrbt_pkg.sv
// ----------------------------------------------------------------------------
// rrbt_pkg
// Types and constants shared by the region reuse backoff tracker.
// ----------------------------------------------------------------------------
package rrbt_pkg;

  localparam int MAX_STAGES = 8;
  localparam int MAX_AREAS  = 16;
  localparam int STAGE_W    = $clog2(MAX_STAGES);
  localparam int SLOT_W     = STAGE_W + 1;
  localparam int AREA_IDX_W = $clog2(MAX_AREAS);
  localparam int CNT_W      = AREA_IDX_W + 1;
  localparam int NSLOTS     = 2 * MAX_STAGES;
  localparam int ADDR_W     = SLOT_W + AREA_IDX_W;
  localparam int NRECTS     = NSLOTS * MAX_AREAS;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 28;
  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_AREA = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_CAP = 1'd1;

  localparam logic [27:0] MIN_AREA_RESET = 28'd100;
  localparam logic [6:0]  SKIP_CAP_RESET = 7'd64;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_SMALL = 3'd1,
    ST_FULL      = 3'd2,
    ST_BAD_TICK  = 3'd3,
    ST_PENDING   = 3'd4
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_Q_CHK,
    S_Q_SCAN,
    S_Q_SKIPRD,
    S_Q_SKIP,
    S_Q_WRITE,
    S_R_READ,
    S_R_AREA,
    S_R_WRITE,
    S_DONE
  } state_t;

endpackage

// File: sv/region_reuse_backoff_tracker.sv
// ----------------------------------------------------------------------------
// region_reuse_backoff_tracker
// Decides per rectangle and stage whether a region finder runs this frame.
// ----------------------------------------------------------------------------
// The tracker takes one request at a time: it accepts the next one once the result
//   of the last has been loaded into the output register.
// Reset (rst, synchronous): counters, flags, bank and configuration reset;
//   the rectangle and skip memories are not cleared.
module region_reuse_backoff_tracker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [rrbt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rrbt_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // vp_x, vp_y, vp_w, vp_h, stage, frame_number, ticket_in, found_area
  input  logic [rrbt_pkg::IN_DATA_W-1:0]      s_tdata,
  // mode
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // use_finder, ticket_out, status, skip_left
  output logic [rrbt_pkg::OUT_DATA_W-1:0]     m_tdata
);
  import rrbt_pkg::*;

  state_t state, state_next;

  logic [27:0] min_area;
  logic [6:0]  skip_cap;

  logic signed [15:0] q_x, q_y;
  logic [13:0] q_w, q_h;
  logic [STAGE_W-1:0] q_stage;
  logic [31:0] q_frame;
  logic [27:0] q_found, q_area;

  logic bank;
  logic [31:0] last_frame;
  logic [STAGE_W-1:0] last_stage;
  logic pending;
  logic [7:0] ticket_ctr;
  logic [CNT_W-1:0] cnt [NSLOTS];
  logic seen [NSLOTS];

  logic [CNT_W-1:0] scan_i;
  logic s1_vld, ov_vld;
  logic [27:0] ov, best;
  logic [AREA_IDX_W-1:0] ov_idx, best_idx;
  logic [6:0] ls, sk;
  logic positive;
  logic [27:0] r_area;

  logic res_use;
  logic [7:0] res_ticket;
  status_t res_status;
  logic [6:0] res_left;

  // Memories
  logic [59:0] rect_mem [NRECTS];
  logic [13:0] skip_mem [NRECTS];
  logic [59:0] rect_q;
  logic [13:0] skip_q;
  logic rd_en, rect_we, skip_we;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [59:0] rect_wd;
  logic [13:0] skip_wd;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rect_q <= rect_mem[rd_addr];
      skip_q <= skip_mem[rd_addr];
    end
    if (rect_we) rect_mem[wr_addr] <= rect_wd;
    if (skip_we) skip_mem[wr_addr] <= skip_wd;
  end

  logic [SLOT_W-1:0] cur_slot, prv_slot, rep_slot;
  logic [CNT_W-1:0] scan_n, rep_cnt;
  logic [AREA_IDX_W-1:0] rep_idx;
  logic scan_done, match, cur_full, s_acc, out_load;

  assign cur_slot = {bank, q_stage};
  assign prv_slot = {~bank, q_stage};
  assign rep_slot = {bank, last_stage};
  assign scan_n   = seen[prv_slot] ? cnt[prv_slot] : '0;
  assign rep_cnt  = cnt[rep_slot];
  assign rep_idx  = (rep_cnt == '0) ? '0 : AREA_IDX_W'(rep_cnt - CNT_W'(1));
  assign scan_done = (scan_i == scan_n) && !s1_vld && !ov_vld;
  assign cur_full = (cnt[cur_slot] >= CNT_W'(MAX_AREAS));
  assign s_tready = (state == S_IDLE);
  assign s_acc    = s_tvalid && s_tready;
  assign out_load = (state == S_DONE) && (!m_tvalid || m_tready);

  // Strong match: best >= floor(2*area/3), written as 2*area <= 3*best + 2.
  logic [29:0] best3;
  assign best3 = {best, 1'b0} + {2'b0, best} + 30'd2;
  assign match = (best != '0) && ({1'b0, q_area, 1'b0} <= best3);

  // Overlap of the stored rectangle just read with the query rectangle.
  logic signed [17:0] rx0, ry0, rx1, ry1, qx0, qy0, qx1, qy1;
  logic signed [17:0] sx, sy, ex, ey, dx, dy;
  logic [27:0] ov_comb;
  always_comb begin
    rx0 = 18'(signed'(rect_q[59:44]));
    ry0 = 18'(signed'(rect_q[43:28]));
    rx1 = rx0 + signed'({4'b0, rect_q[27:14]});
    ry1 = ry0 + signed'({4'b0, rect_q[13:0]});
    qx0 = 18'(q_x);
    qy0 = 18'(q_y);
    qx1 = qx0 + signed'({4'b0, q_w});
    qy1 = qy0 + signed'({4'b0, q_h});
    sx  = (rx0 > qx0) ? rx0 : qx0;
    sy  = (ry0 > qy0) ? ry0 : qy0;
    ex  = (rx1 < qx1) ? rx1 : qx1;
    ey  = (ry1 < qy1) ? ry1 : qy1;
    dx  = ex - sx;
    dy  = ey - sy;
    if (dx <= 18'sd0 || dy <= 18'sd0) ov_comb = '0;
    else ov_comb = dx[13:0] * dy[13:0];
  end

  // Report decision: found < floor(4*area/5), written as 5*found + 5 <= 4*area.
  logic [30:0] found5;
  logic low_found;
  logic [7:0] ls_dbl;
  logic [6:0] ls_cap;
  assign found5    = {1'b0, q_found, 2'b0} + {3'b0, q_found} + 31'd5;
  assign low_found = found5 <= {1'b0, r_area, 2'b0};
  assign ls_dbl    = {skip_q[13:7], 1'b1};
  assign ls_cap    = (ls_dbl > {1'b0, skip_cap}) ? skip_cap : ls_dbl[6:0];

  always_comb begin
    state_next = state;
    rd_en   = 1'b0;
    rd_addr = '0;
    rect_we = 1'b0;
    skip_we = 1'b0;
    wr_addr = {cur_slot, cnt[cur_slot][AREA_IDX_W-1:0]};
    rect_wd = {q_x, q_y, q_w, q_h};
    skip_wd = {ls, sk};
    case (state)
      S_IDLE: begin
        if (s_acc) begin
          if (s_tuser) begin
            if (!pending || s_tdata[102:95] != ticket_ctr) state_next = S_DONE;
            else state_next = S_R_READ;
          end else if (pending) begin
            state_next = S_DONE;
          end else begin
            state_next = S_Q_CHK;
          end
        end
      end
      S_Q_CHK: state_next = (q_area < min_area) ? S_DONE : S_Q_SCAN;
      S_Q_SCAN: begin
        rd_en   = (scan_i < scan_n);
        rd_addr = {prv_slot, scan_i[AREA_IDX_W-1:0]};
        if (scan_done) state_next = match ? S_Q_SKIPRD : S_Q_WRITE;
      end
      S_Q_SKIPRD: begin
        rd_en   = 1'b1;
        rd_addr = {prv_slot, best_idx};
        state_next = S_Q_SKIP;
      end
      S_Q_SKIP: state_next = S_Q_WRITE;
      S_Q_WRITE: begin
        rect_we = !cur_full;
        skip_we = !cur_full;
        state_next = S_DONE;
      end
      S_R_READ: begin
        rd_en   = 1'b1;
        rd_addr = {rep_slot, rep_idx};
        state_next = S_R_AREA;
      end
      S_R_AREA: state_next = S_R_WRITE;
      S_R_WRITE: begin
        skip_we = 1'b1;
        wr_addr = {rep_slot, rep_idx};
        skip_wd = low_found ? {7'd0, skip_q[6:0]} : {ls_cap, ls_cap};
        state_next = S_DONE;
      end
      S_DONE: if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // Configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      min_area <= MIN_AREA_RESET;
      skip_cap <= SKIP_CAP_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MIN_AREA: min_area <= cfg_data;
        CFG_SKIP_CAP: skip_cap <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  // Request fields
  always_ff @(posedge clk) begin
    if (s_acc) begin
      q_x     <= signed'(s_tdata[15:0]);
      q_y     <= signed'(s_tdata[31:16]);
      q_w     <= s_tdata[45:32];
      q_h     <= s_tdata[59:46];
      q_stage <= s_tdata[62:60];
      q_frame <= s_tdata[94:63];
      q_found <= s_tdata[130:103];
      q_area  <= s_tdata[45:32] * s_tdata[59:46];
    end
    if (state == S_R_AREA) r_area <= rect_q[27:14] * rect_q[13:0];
  end

  // Control state, scan and result
  always_ff @(posedge clk) begin
    if (rst) begin
      bank       <= 1'b0;
      last_frame <= '0;
      last_stage <= '0;
      pending    <= 1'b0;
      ticket_ctr <= '0;
      for (int i = 0; i < NSLOTS; i++) begin
        cnt[i]  <= '0;
        seen[i] <= 1'b0;
      end
      s1_vld   <= 1'b0;
      ov_vld   <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
        m_tdata  <= {5'd0, res_left, res_status, res_ticket, res_use};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_acc) begin
            res_use    <= 1'b0;
            res_ticket <= '0;
            res_left   <= '0;
            res_status <= ST_OK;
            if (s_tuser) begin
              if (!pending || s_tdata[102:95] != ticket_ctr) res_status <= ST_BAD_TICK;
            end else if (pending) begin
              res_status <= ST_PENDING;
            end
          end
        end
        S_Q_CHK: begin
          if (q_area < min_area) begin
            res_status <= ST_TOO_SMALL;
          end else begin
            if (q_frame != last_frame) begin
              bank <= ~bank;
              for (int i = 0; i < MAX_STAGES; i++) begin
                cnt[{~bank, STAGE_W'(i)}]  <= '0;
                seen[{~bank, STAGE_W'(i)}] <= 1'b0;
              end
              last_frame <= q_frame;
            end
            last_stage <= q_stage;
            scan_i   <= '0;
            best     <= '0;
            best_idx <= '0;
            s1_vld   <= 1'b0;
            ov_vld   <= 1'b0;
            ls       <= '0;
            sk       <= '0;
            positive <= 1'b1;
          end
        end
        S_Q_SCAN: begin
          // Three-step pipe: read, overlap product, compare with the best.
          s1_vld <= (scan_i < scan_n);
          if (scan_i < scan_n) scan_i <= scan_i + CNT_W'(1);
          ov_vld <= s1_vld;
          ov     <= ov_comb;
          if (ov_vld && ov > best) begin
            best     <= ov;
            best_idx <= ov_idx;
          end
          if (s1_vld) ov_idx <= scan_i[AREA_IDX_W-1:0] - AREA_IDX_W'(1);
        end
        S_Q_SKIP: begin
          ls <= skip_q[13:7];
          if (skip_q[6:0] != '0) begin
            sk       <= skip_q[6:0] - 7'd1;
            positive <= 1'b0;
          end
        end
        S_Q_WRITE: begin
          seen[cur_slot] <= 1'b1;
          if (cur_full) begin
            res_status <= ST_FULL;
          end else begin
            cnt[cur_slot] <= cnt[cur_slot] + CNT_W'(1);
            res_left <= sk;
            if (positive) begin
              ticket_ctr <= ticket_ctr + 8'd1;
              res_ticket <= ticket_ctr + 8'd1;
              res_use    <= 1'b1;
              pending    <= 1'b1;
            end
          end
        end
        S_R_WRITE: begin
          pending  <= 1'b0;
          res_left <= low_found ? skip_q[6:0] : ls_cap;
        end
        default: ;
      endcase
    end
  end

  // The best overlap never exceeds the query area.
  a_best_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_Q_SCAN) |-> (best <= q_area))
    else $error("best overlap above query area");

  // A positive answer leaves a report pending.
  a_pending_after_ticket: assert property (@(posedge clk) disable iff (rst)
    (state == S_Q_WRITE && !cur_full && positive) |=> pending)
    else $error("ticket issued without pending report");

  // A report is only written back while one is pending.
  a_report_pending: assert property (@(posedge clk) disable iff (rst)
    (state == S_R_WRITE) |-> pending)
    else $error("report processed without pending query");

endmodule

// File: sim/rrbt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrbt_checker
// Watches the request and result streams of the region reuse backoff
// tracker, predicts each result from its own copy of the tables, and counts
// every result that differs from the prediction.
// ----------------------------------------------------------------------------
module rrbt_checker
  import rrbt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tuser,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,
  output int                    errors,
  output logic                  awaiting_report,
  output logic [7:0]            issued_ticket,
  output int                    outstanding
);

  typedef struct packed {
    logic       use_finder;
    logic [7:0] ticket;
    status_t    status;
    logic [6:0] skip_left;
  } decision_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [13:0]        w;
    logic [13:0]        h;
  } rect_t;

  rect_t      rects   [NRECTS];
  logic [6:0] backoff [NRECTS];
  logic [6:0] skips   [NRECTS];
  int         n_rects [NSLOTS];
  logic       seen    [NSLOTS];
  logic       bank;
  logic [31:0] cur_frame;
  int          last_stage;
  logic [27:0] min_area;
  logic [6:0]  skip_cap;
  decision_t   decisions[$];

  function automatic longint overlap(rect_t r, int x, int y, int w, int h);
    int sx, sy, ex, ey;
    sx = (int'(r.x) > x) ? int'(r.x) : x;
    sy = (int'(r.y) > y) ? int'(r.y) : y;
    ex = (int'(r.x) + int'(r.w) < x + w) ? int'(r.x) + int'(r.w) : x + w;
    ey = (int'(r.y) + int'(r.h) < y + h) ? int'(r.y) + int'(r.h) : y + h;
    if (ex <= sx || ey <= sy) return 0;
    return longint'(ex - sx) * longint'(ey - sy);
  endfunction

  task automatic decide(input logic is_report, input logic [IN_DATA_W-1:0] d,
                        output decision_t res);
    rect_t      q;
    logic [2:0] stg;
    logic [31:0] frame;
    logic [7:0] tick_in;
    longint     found, area, best, a;
    int         slot, idx, cur, prv, bi, n;
    logic [6:0] ls, sk;
    logic       positive;
    res = '0;
    res.status = ST_OK;
    q = '{x: d[15:0], y: d[31:16], w: d[45:32], h: d[59:46]};
    stg = d[62:60];
    frame = d[94:63];
    tick_in = d[102:95];
    found = longint'(d[130:103]);
    area = longint'(q.w) * longint'(q.h);
    if (is_report) begin
      if (!awaiting_report || tick_in != issued_ticket) begin
        res.status = ST_BAD_TICK;
      end else begin
        slot = int'(bank) * MAX_STAGES + last_stage;
        idx = slot * MAX_AREAS + (n_rects[slot] > 0 ? n_rects[slot] - 1 : 0);
        area = longint'(rects[idx].w) * longint'(rects[idx].h);
        ls = backoff[idx];
        sk = skips[idx];
        if (found < area * 4 / 5) begin
          ls = '0;
        end else begin
          ls = (int'(ls) * 2 + 1 > int'(skip_cap)) ? skip_cap : 7'(int'(ls) * 2 + 1);
          sk = ls;
        end
        backoff[idx] = ls;
        skips[idx] = sk;
        awaiting_report = 1'b0;
        res.skip_left = sk;
      end
    end else if (awaiting_report) begin
      res.status = ST_PENDING;
    end else if (area < longint'(min_area)) begin
      res.status = ST_TOO_SMALL;
    end else begin
      ls = '0;
      sk = '0;
      positive = 1'b1;
      // A new frame number flips the banks and empties the new current one.
      if (frame != cur_frame) begin
        bank = ~bank;
        for (int i = 0; i < MAX_STAGES; i++) begin
          n_rects[int'(bank) * MAX_STAGES + i] = 0;
          seen[int'(bank) * MAX_STAGES + i] = 1'b0;
        end
        cur_frame = frame;
      end
      cur = int'(bank) * MAX_STAGES + int'(stg);
      prv = int'(!bank) * MAX_STAGES + int'(stg);
      last_stage = int'(stg);
      if (seen[prv]) begin
        best = 0;
        bi = 0;
        n = n_rects[prv];
        for (int i = 0; i < n; i++) begin
          a = overlap(rects[prv * MAX_AREAS + i], q.x, q.y, q.w, q.h);
          if (a > best) begin
            best = a;
            bi = i;
            if (a == area) break;
          end
        end
        if (best >= area * 2 / 3 && best > 0) begin
          ls = backoff[prv * MAX_AREAS + bi];
          if (skips[prv * MAX_AREAS + bi] != '0) begin
            sk = skips[prv * MAX_AREAS + bi] - 7'd1;
            positive = 1'b0;
          end
        end
      end
      seen[cur] = 1'b1;
      if (n_rects[cur] >= MAX_AREAS) begin
        res.status = ST_FULL;
      end else begin
        idx = cur * MAX_AREAS + n_rects[cur];
        rects[idx] = q;
        backoff[idx] = ls;
        skips[idx] = sk;
        n_rects[cur]++;
        res.skip_left = sk;
        if (positive) begin
          issued_ticket = issued_ticket + 8'd1;
          res.ticket = issued_ticket;
          awaiting_report = 1'b1;
          res.use_finder = 1'b1;
        end
      end
    end
  endtask

  always @(posedge clk) begin
    decision_t want, got;
    if (rst) begin
      for (int i = 0; i < NSLOTS; i++) begin
        n_rects[i] = 0;
        seen[i] = 1'b0;
      end
      bank = 1'b0;
      cur_frame = '0;
      last_stage = 0;
      awaiting_report = 1'b0;
      issued_ticket = '0;
      min_area = MIN_AREA_RESET;
      skip_cap = SKIP_CAP_RESET;
      decisions.delete();
      outstanding = 0;
      errors = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_MIN_AREA) min_area = cfg_data;
        else if (cfg_index == CFG_SKIP_CAP) skip_cap = cfg_data[6:0];
      end
      if (m_tvalid && m_tready) begin
        got = '{use_finder: m_tdata[0], ticket: m_tdata[8:1],
                status: status_t'(m_tdata[11:9]), skip_left: m_tdata[18:12]};
        if (decisions.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result %h", m_tdata);
        end else begin
          want = decisions.pop_front();
          if (got.use_finder != want.use_finder || got.ticket != want.ticket ||
              got.status != want.status || got.skip_left != want.skip_left) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: use %0d/%0d ticket %0d/%0d status %0d/%0d skip %0d/%0d",
                       want.use_finder, got.use_finder, want.ticket, got.ticket,
                       want.status, got.status, want.skip_left, got.skip_left);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        decide(s_tuser, s_tdata, want);
        decisions.insert(decisions.size(), want);
      end
      outstanding = decisions.size();
    end
  end

endmodule

// File: sim/tb_region_reuse_backoff_tracker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_region_reuse_backoff_tracker
// Drives queries and reports into the tracker under several stall patterns
// and configurations; the checker predicts and compares each decision.
// ----------------------------------------------------------------------------
module tb_region_reuse_backoff_tracker;
  import rrbt_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;

  int          errors;
  logic        awaiting_report;
  logic [7:0]  issued_ticket;
  int          outstanding;
  int          cycles;
  int          send_idle;
  int          recv_stall;
  int          n_queries;
  int          n_reports;
  int          frame_left;
  logic [31:0] frame;
  longint      last_area;
  int          base_x [8][4];
  int          base_y [8][4];
  int          base_w [8][4];
  int          base_h [8][4];

  region_reuse_backoff_tracker i_dut (.*);

  rrbt_checker i_checker (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(negedge clk)
    m_tready = (recv_stall == 0) ? 1'b1 : ($urandom_range(99) >= recv_stall);

  function automatic logic [IN_DATA_W-1:0] pack(int x, int y, int w, int h, int stg,
                                               logic [31:0] fr, logic [7:0] tk,
                                               logic [27:0] found);
    logic [IN_DATA_W-1:0] d;
    d = '0;
    d[15:0] = x[15:0];
    d[31:16] = y[15:0];
    d[45:32] = w[13:0];
    d[59:46] = h[13:0];
    d[62:60] = stg[2:0];
    d[94:63] = fr;
    d[102:95] = tk;
    d[130:103] = found;
    return d;
  endfunction

  task automatic send(input logic is_report, input logic [IN_DATA_W-1:0] d);
    while (send_idle != 0 && $urandom_range(99) < send_idle) begin
      s_tvalid = 0;
      @(negedge clk);
    end
    s_tvalid = 1;
    s_tdata = d;
    s_tuser = is_report;
    if (is_report) n_reports++;
    else n_queries++;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic query(int x, int y, int w, int h, int stg, logic [31:0] fr);
    last_area = longint'(w[13:0]) * longint'(h[13:0]);
    send(0, pack(x, y, w, h, stg, fr, 8'($urandom), 28'($urandom)));
  endtask

  task automatic report(logic [7:0] tk, logic [27:0] found);
    send(1, pack($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, tk, found));
  endtask

  // Holds the request stream until every decision is back and the block is idle.
  task automatic drain();
    s_tvalid = 0;
    while (outstanding != 0) @(negedge clk);
    repeat (40) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
  endtask

  function automatic logic [27:0] pick_found();
    case ($urandom_range(4))
      0: return '0;
      1: return last_area[27:0];
      2: return 28'(last_area * 4 / 5);
      3: return (last_area * 4 / 5 > 0) ? 28'(last_area * 4 / 5 - 1) : 28'd0;
      default: return 28'($urandom);
    endcase
  endfunction

  task automatic random_item();
    int s, b, w, h;
    if ($urandom_range(99) < 7) begin
      if ($urandom_range(1)) report(8'($urandom), 28'($urandom));
      else query($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    end else if (awaiting_report && $urandom_range(99) < 90) begin
      report(($urandom_range(99) < 95) ? issued_ticket : 8'($urandom), pick_found());
    end else begin
      if (frame_left <= 0) begin
        frame = ($urandom_range(9) == 0) ? 32'($urandom) : frame + 1;
        frame_left = $urandom_range(5, 60);
      end
      frame_left--;
      s = ($urandom_range(1)) ? $urandom_range(2) : $urandom_range(7);
      b = $urandom_range(3);
      w = base_w[s][b] + $urandom_range(6) - 3;
      h = base_h[s][b] + $urandom_range(6) - 3;
      if ($urandom_range(49) == 0) w = 0;
      query(base_x[s][b] + $urandom_range(8) - 4, base_y[s][b] + $urandom_range(8) - 4,
            w, h, s, frame);
    end
  endtask

  task automatic run_phase(int idle, int stall, int items);
    send_idle = idle;
    recv_stall = stall;
    repeat (items) random_item();
    drain();
  endtask

  initial begin
    cycles = 0;
    n_queries = 0;
    n_reports = 0;
    send_idle = 0;
    recv_stall = 0;
    frame = 5;
    frame_left = 0;
    last_area = 0;
    rst = 1;
    cfg_we = 0;
    cfg_index = CFG_MIN_AREA;
    cfg_data = '0;
    s_tvalid = 0;
    s_tdata = '0;
    s_tuser = 0;
    for (int s = 0; s < 8; s++)
      for (int b = 0; b < 4; b++) begin
        base_x[s][b] = int'($urandom_range(65535)) - 32768;
        base_y[s][b] = int'($urandom_range(65535)) - 32768;
        base_w[s][b] = $urandom_range(12, 120);
        base_h[s][b] = $urandom_range(12, 120);
      end
    repeat (3) @(negedge clk);
    rst = 0;

    // Directed: size threshold, stray and wrong tickets, pending query,
    // coordinate and field extremes, then a stage filled past capacity.
    query(0, 0, 9, 11, 0, 1);
    report(0, 0);
    query(0, 0, 10, 10, 0, 1);
    query(0, 0, 10, 10, 0, 1);
    report(8'hFF, 28'hFFFFFFF);
    report(issued_ticket, 100);
    query(-32768, 32767, 16383, 16383, 7, 32'hFFFFFFFF);
    report(issued_ticket, 28'hFFFFFFF);
    query(32767, -32768, 16383, 16383, 7, 32'h0);
    report(issued_ticket, 0);
    for (int i = 0; i < 17; i++) begin
      query(i * 20, 0, 15, 15, 3, 32'h0);
      if (awaiting_report) report(issued_ticket, 200);
    end
    drain();

    run_phase(0, 0, 380);
    write_reg(CFG_MIN_AREA, 0);
    write_reg(CFG_SKIP_CAP, 1);
    run_phase(70, 0, 380);
    write_reg(CFG_MIN_AREA, 28'hFFFFFFF);
    write_reg(CFG_SKIP_CAP, 64);
    run_phase(0, 70, 40);
    write_reg(CFG_MIN_AREA, 50);
    write_reg(CFG_SKIP_CAP, 7);
    run_phase(0, 70, 380);
    write_reg(CFG_MIN_AREA, 100);
    write_reg(CFG_SKIP_CAP, 64);
    run_phase(31, 31, 380);
    run_phase(0, 0, 380);

    $display("Covered %0d queries and %0d reports under four stall patterns", n_queries,
             n_reports);
    $display("and minimum areas from zero to the maximum with skip caps of 1, 7 and 64.");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: files.f
sv/rrbt_pkg.sv
sv/region_reuse_backoff_tracker.sv
sim/rrbt_checker.sv
sim/tb_region_reuse_backoff_tracker.sv
